FILE: hw/rtl/rgba2bmp_pkg.sv
// Shared types, constants and header byte lookup for the RGBA to BMP encoder.
`timescale 1ns / 1ps

package rgba2bmp_pkg;

	localparam int CHAN_W     = 8;
	localparam int DIM_W      = 14;
	localparam int POS_W      = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int STRIDE_W   = 15;
	localparam int SIZE_W     = 29;
	localparam int BYTE_IDX_W = 6;

	localparam logic [DIM_W-1:0] MAX_DIMENSION = 14'd8192;

	localparam logic [BYTE_IDX_W-1:0] HEADER_BYTES = 6'd54;
	localparam logic [7:0] INFO_SIZE   = 8'd40;
	localparam logic [7:0] BPP         = 8'd24;
	localparam logic [7:0] CHAR_B      = 8'h42;
	localparam logic [7:0] CHAR_M      = 8'h4D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [DIM_W-1:0]  dim_t;
	typedef logic [SIZE_W-1:0] size_t;

	// zero acts as one, anything above the limit is clamped
	function automatic dim_t eff_dim(input dim_t v);
		dim_t r;
		r = v;
		if (v == '0)
			r = 14'd1;
		else if (v > MAX_DIMENSION)
			r = MAX_DIMENSION;
		return r;
	endfunction

	// byte k of the 54-byte file and info header
	function automatic logic [7:0] hdr_byte(input logic [BYTE_IDX_W-1:0] k,
		input dim_t w, input dim_t h, input size_t file_sz, input size_t data_sz);
		logic [31:0] f32;
		logic [31:0] d32;
		logic [15:0] w16;
		logic [15:0] h16;
		logic [7:0]  b;
		f32 = {{(32-SIZE_W){1'b0}}, file_sz};
		d32 = {{(32-SIZE_W){1'b0}}, data_sz};
		w16 = {{(16-DIM_W){1'b0}}, w};
		h16 = {{(16-DIM_W){1'b0}}, h};
		case (k)
			6'd0:  b = CHAR_B;
			6'd1:  b = CHAR_M;
			6'd2:  b = f32[7:0];
			6'd3:  b = f32[15:8];
			6'd4:  b = f32[23:16];
			6'd5:  b = f32[31:24];
			6'd10: b = {2'b00, HEADER_BYTES};
			6'd14: b = INFO_SIZE;
			6'd18: b = w16[7:0];
			6'd19: b = w16[15:8];
			6'd22: b = h16[7:0];
			6'd23: b = h16[15:8];
			6'd26: b = 8'd1;
			6'd28: b = BPP;
			6'd34: b = d32[7:0];
			6'd35: b = d32[15:8];
			6'd36: b = d32[23:16];
			6'd37: b = d32[31:24];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

FILE: hw/rtl/rgba2bmp_if.sv
// Handshake interfaces for the pixel input and the BMP byte output.
`timescale 1ns / 1ps

interface rgba2bmp_pixel_if import rgba2bmp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface rgba2bmp_byte_if import rgba2bmp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] out_byte;
	logic              run_last;
	logic              file_end;

	modport source (output valid, out_byte, run_last, file_end, input ready);
	modport sink   (input valid, out_byte, run_last, file_end, output ready);
endinterface

FILE: hw/rtl/rgba_to_bmp24_stream_encoder.sv
// Top level: RGBA pixel stream in, 24-bit BMP byte stream out.
//
//  channel  dir  payload                          accepted when
//  pixel    in   red, green, blue, alpha          pixel.valid && pixel.ready
//  stream   out  out_byte, run_last, file_end     stream.valid && stream.ready
//  cfg      in   cfg_index, cfg_data              cfg_write
//
// One output byte per cycle while stream is ready: a pixel gives 3 bytes, plus
// 54 header bytes at the start of a frame and up to 3 pad bytes at a row end.
// A new pixel is taken in the cycle its predecessor's last byte moves to the
// output register. Reset (arst_n low) clears position, header flag and valids,
// and sets both dimensions to 1. A stall on stream holds the output register
// and the pixel in progress.
`timescale 1ns / 1ps

module rgba_to_bmp24_stream_encoder import rgba2bmp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	rgba2bmp_pixel_if.sink       pixel,
	rgba2bmp_byte_if.source      stream
);

	dim_t width_q, height_q;
	logic [POS_W-1:0] col_q, row_q;
	logic hdr_sent_q;

	// item in progress
	logic              hold_v_s1;
	logic [CHAN_W-1:0] red_s1, green_s1, blue_s1, alpha_s1;
	logic              hdr_s1, row_end_s1, frame_s1;
	logic [1:0]        pad_s1;
	dim_t              w_s1, h_s1;
	logic [BYTE_IDX_W-1:0] k_q;
	size_t             data_q;

	// output register
	logic              out_v_q;
	logic [CHAN_W-1:0] out_byte_q;
	logic              run_last_q, file_end_q;

	dim_t w_eff, h_eff;
	logic row_end, frame_end;
	logic accept, adv, last;
	logic [BYTE_IDX_W-1:0] last_k, j;
	logic [STRIDE_W-1:0] stride;
	size_t file_sz;
	logic [CHAN_W-1:0] chan, comp, byte_nx;
	logic [2*CHAN_W-1:0] prod;
	logic [2*CHAN_W:0] rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 14'd1;
			height_q <= 14'd1;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	assign w_eff     = eff_dim(width_q);
	assign h_eff     = eff_dim(height_q);
	assign row_end   = ({1'b0, col_q} + 14'd1) >= w_eff;
	assign frame_end = row_end && (({1'b0, row_q} + 14'd1) >= h_eff);

	// byte sequencing of the held item
	assign last_k = (hdr_s1 ? 6'd56 : 6'd2) + (row_end_s1 ? {4'b0, pad_s1} : 6'd0);
	assign last   = (k_q == last_k);
	assign adv    = hold_v_s1 && (!out_v_q || stream.ready);
	assign pixel.ready = !hold_v_s1 || (adv && last);
	assign accept = pixel.valid && pixel.ready;

	assign j = hdr_s1 ? (k_q - HEADER_BYTES) : k_q;

	always_comb begin
		case (j[1:0])
			2'd0:    chan = blue_s1;
			2'd1:    chan = green_s1;
			default: chan = red_s1;
		endcase
	end

	// floor(p/255) for p = chan * alpha, at most 255*255
	assign prod = chan * alpha_s1;
	assign rnd  = {1'b0, prod} + {9'b0, prod[15:8]} + 17'd1;
	assign comp = rnd[15:8];

	assign file_sz = data_q + {{(SIZE_W-BYTE_IDX_W){1'b0}}, HEADER_BYTES};

	always_comb begin
		if (hdr_s1 && (k_q < HEADER_BYTES))
			byte_nx = hdr_byte(k_q, w_s1, h_s1, file_sz, data_q);
		else if (j < 6'd3)
			byte_nx = comp;
		else
			byte_nx = 8'd0;
	end

	// 3w plus pad, pad equals w mod 4
	assign stride = {w_s1, 1'b0} + {1'b0, w_s1} + {{(STRIDE_W-2){1'b0}}, w_s1[1:0]};

	always_ff @(posedge clk) begin
		data_q <= SIZE_W'(stride * h_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			hdr_sent_q <= 1'b0;
			hold_v_s1  <= 1'b0;
			k_q        <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (accept) begin
				hold_v_s1 <= 1'b1;
				k_q       <= '0;
				if (row_end) begin
					col_q <= '0;
					if (frame_end) begin
						row_q      <= '0;
						hdr_sent_q <= 1'b0;
					end else begin
						row_q      <= row_q + 13'd1;
						hdr_sent_q <= 1'b1;
					end
				end else begin
					col_q      <= col_q + 13'd1;
					hdr_sent_q <= 1'b1;
				end
			end else if (adv) begin
				if (last)
					hold_v_s1 <= 1'b0;
				else
					k_q <= k_q + 6'd1;
			end
			if (adv)
				out_v_q <= 1'b1;
			else if (stream.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1     <= pixel.red;
			green_s1   <= pixel.green;
			blue_s1    <= pixel.blue;
			alpha_s1   <= pixel.alpha;
			hdr_s1     <= !hdr_sent_q;
			row_end_s1 <= row_end;
			frame_s1   <= frame_end;
			pad_s1     <= w_eff[1:0];
			w_s1       <= w_eff;
			h_s1       <= h_eff;
		end
		if (adv) begin
			out_byte_q <= byte_nx;
			run_last_q <= last;
			file_end_q <= last && frame_s1;
		end
	end

	assign stream.valid    = out_v_q;
	assign stream.out_byte = out_byte_q;
	assign stream.run_last = run_last_q;
	assign stream.file_end = file_end_q;

endmodule

FILE: verif/rgba_to_bmp24_stream_encoder_checker.sv
// Byte stream predictor and comparator for the RGBA to BMP encoder.
`timescale 1ns / 1ps

module rgba_to_bmp24_stream_encoder_checker import rgba2bmp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	rgba2bmp_pixel_if            pixel,
	rgba2bmp_byte_if             stream,
	output int unsigned          errors,
	output int unsigned          bytes_owed
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       fend;
	} bmp_byte_t;

	bmp_byte_t        file_bytes_q[$];
	bmp_byte_t        want;
	dim_t             width_reg;
	dim_t             height_reg;
	logic [POS_W-1:0] col;
	logic [POS_W-1:0] row;
	logic             frame_open;
	int unsigned      fails = 0;
	int unsigned      owed = 0;
	int unsigned      bytes_seen = 0;

	assign errors     = fails;
	assign bytes_owed = owed;

	task automatic report(input string what, input int unsigned got, input int unsigned exp);
		$display("%0t: byte %0d: %s is %0h, expected %0h", $time, bytes_seen, what, got, exp);
		fails++;
	endtask

	function automatic int unsigned clamp_dim(input dim_t v);
		if (v == '0)
			return 1;
		if (v > MAX_DIMENSION)
			return MAX_DIMENSION;
		return v;
	endfunction

	// black background: floor(c * a / 255)
	function automatic logic [7:0] shade(input logic [7:0] c, input logic [7:0] a);
		int unsigned p;
		p = c * a;
		return 8'(p / 255);
	endfunction

	task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a);
		logic [7:0]  seq[$];
		logic [31:0] words[13];
		int unsigned w;
		int unsigned h;
		int unsigned pad;
		logic [31:0] data_sz;
		logic        frame_done;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		pad = (4 - ((w * 3) & 3)) & 3;
		frame_done = 1'b0;
		if (!frame_open) begin
			data_sz = (w * 3 + pad) * h;
			words = '{data_sz + 32'(HEADER_BYTES), 32'd0, 32'(HEADER_BYTES), 32'(INFO_SIZE),
				w, h, {8'd0, BPP, 16'd1}, 32'd0, data_sz, 32'd0, 32'd0, 32'd0, 32'd0};
			seq.push_back(CHAR_B);
			seq.push_back(CHAR_M);
			foreach (words[k])
				for (int j = 0; j < 4; j++)
					seq.push_back(words[k][8*j +: 8]);
			frame_open = 1'b1;
		end
		seq.push_back(shade(b, a));
		seq.push_back(shade(g, a));
		seq.push_back(shade(r, a));
		// width or height may have shrunk mid-frame, so compare with >=
		if (col + 1 >= w) begin
			for (int i = 0; i < pad; i++)
				seq.push_back(8'd0);
			col = '0;
			if (row + 1 >= h) begin
				row = '0;
				frame_open = 1'b0;
				frame_done = 1'b1;
			end else begin
				row++;
			end
		end else begin
			col++;
		end
		for (int i = 0; i < seq.size(); i++)
			file_bytes_q.push_back('{seq[i], i == seq.size() - 1,
				(i == seq.size() - 1) && frame_done});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_bytes_q.delete();
			width_reg = 14'd1;
			height_reg = 14'd1;
			col = '0;
			row = '0;
			frame_open = 1'b0;
			owed = 0;
		end else begin
			// outputs first: a byte seen at this edge never belongs to a pixel taken now
			if (stream.valid && stream.ready) begin
				if (file_bytes_q.size() == 0) begin
					report("unexpected out_byte", stream.out_byte, 0);
				end else begin
					want = file_bytes_q.pop_front();
					if (stream.out_byte !== want.data)
						report("out_byte", stream.out_byte, want.data);
					if (stream.run_last !== want.last)
						report("run_last", stream.run_last, want.last);
					if (stream.file_end !== want.fend)
						report("file_end", stream.file_end, want.fend);
				end
				bytes_seen++;
			end
			if (pixel.valid && pixel.ready)
				predict_pixel(pixel.red, pixel.green, pixel.blue, pixel.alpha);
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_WIDTH:  width_reg = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			owed = file_bytes_q.size();
		end
	end

endmodule

FILE: verif/rgba_to_bmp24_stream_encoder_test.sv
// Top of the RGBA to BMP encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rgba_to_bmp24_stream_encoder_test;
	import rgba2bmp_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 20;
	localparam int PIXEL_TARGET = 280;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 calm;
	int unsigned          fails;
	int unsigned          owed;
	int unsigned          pixels_sent = 0;
	int                   idle_cycles = 0;
	int                   stall_left = 0;

	rgba2bmp_pixel_if pixel();
	rgba2bmp_byte_if  stream();

	rgba_to_bmp24_stream_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.stream    (stream)
	);

	rgba_to_bmp24_stream_encoder_checker bmp_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel      (pixel),
		.stream     (stream),
		.errors     (fails),
		.bytes_owed (owed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	// output side back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			stream.ready <= 1'b0;
		end else begin
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				stream.ready <= 1'b0;
			end else begin
				stream.ready <= 1'b1;
				stall_left <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel.valid && pixel.ready) || (stream.valid && stream.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pixel.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.red <= r;
		pixel.green <= g;
		pixel.blue <= b;
		pixel.alpha <= a;
		do @(posedge clk); while (!pixel.ready);
		pixels_sent++;
	endtask

	task automatic send_shade();
		int roll;
		logic [7:0] a;
		roll = $urandom_range(0, 99);
		a = 8'($urandom_range(0, 255));
		if (roll < 15)
			a = 8'd0;
		else if (roll < 30)
			a = 8'd255;
		send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), a);
	endtask

	// hold the input until every predicted byte is out; sampled on the falling edge
	task automatic drain();
		pixel.valid <= 1'b0;
		do @(negedge clk); while (owed != 0);
		@(posedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		cfg_write <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned count;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data <= '0;
		pixel.valid <= 1'b0;
		pixel.red <= '0;
		pixel.green <= '0;
		pixel.blue <= '0;
		pixel.alpha <= '0;
		calm <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size 1x1: every item is a whole file
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
		send_pixel(8'd128, 8'd64, 8'd1, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd255, 8'd1);
		drain();
		// zero acts as one
		set_dims(14'd0, 14'd0);
		send_pixel(8'd170, 8'd85, 8'd255, 8'd254);
		send_pixel(8'd85, 8'd170, 8'd0, 8'd127);
		drain();
		// oversize clamps to the max; then shrink width below the column mid-row
		set_dims(14'h3FFF, 14'd8193);
		repeat (3) send_shade();
		drain();
		set_dims(14'd2, 14'd1);
		send_shade();
		drain();
		// height shrinks below the current row
		set_dims(14'd3, 14'd3);
		repeat (3) send_shade();
		drain();
		set_dims(14'd3, 14'd1);
		repeat (3) send_shade();
		drain();
		// exact maximum, then finish the frame at width 4
		set_dims(MAX_DIMENSION, MAX_DIMENSION);
		send_shade();
		drain();
		set_dims(14'd4, 14'd1);
		repeat (3) send_shade();

		while (pixels_sent < PIXEL_TARGET) begin
			drain();
			calm <= ($urandom_range(0, 5) == 0);
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 7);
			h = $urandom_range(1, 4);
			if ($urandom_range(0, 19) == 0)
				w = 0;
			if ($urandom_range(0, 19) == 0)
				h = 0;
			set_dims(DIM_W'(w), DIM_W'(h));
			if (w == 0)
				w = 1;
			if (h == 0)
				h = 1;
			count = w * h * $urandom_range(1, 2);
			// sometimes stop mid-frame so the next size lands inside a frame
			if ($urandom_range(0, 3) == 0)
				count = $urandom_range(1, 2 * w * h);
			for (int i = 0; i < count && pixels_sent < PIXEL_TARGET; i++)
				send_shade();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
